[sv/vector3_normalize_unit_macros.svh]
// Assertion macros for the vector normalizer.
// Used by vector3_normalize_unit; the including module provides clk and arst_n.
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define VNU_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// The condition implies the consequence in the cycle after.
`define VNU_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

[sv/vnorm_pkg.sv]
// Types and constants for the vector normalizer.
// No dependencies; used by vector3_normalize_unit.
package vnorm_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int SUM_WIDTH       = 2 * COMPONENT_WIDTH;
	localparam int FRACTION_EXTRA  = 8;
	// Magnitude is floor(sqrt(sum * 2^(2*FRACTION_EXTRA))).
	localparam int ROOT_WIDTH      = SUM_WIDTH / 2 + FRACTION_EXTRA;
	localparam int REM_WIDTH       = ROOT_WIDTH + 3;
	localparam int QUOT_WIDTH      = 15;
	// Partial remainder of the division stays below twice the magnitude.
	localparam int DIVR_WIDTH      = ROOT_WIDTH + 1;
	localparam int DIV_PRESHIFT    = 14 + FRACTION_EXTRA - QUOT_WIDTH;
	localparam int UNIT_WIDTH      = 16;
	localparam int CFG_WIDTH       = 32;
	localparam logic [UNIT_WIDTH-1:0] UNIT_ONE = UNIT_WIDTH'(16384);

	typedef struct packed {
		logic signed [COMPONENT_WIDTH-1:0] in_x;
		logic signed [COMPONENT_WIDTH-1:0] in_y;
		logic signed [COMPONENT_WIDTH-1:0] in_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [UNIT_WIDTH-1:0] unit_x;
		logic signed [UNIT_WIDTH-1:0] unit_y;
		logic signed [UNIT_WIDTH-1:0] unit_z;
		logic                         degenerate;
	} vec_out_t;

	// Everything one item carries down the pipeline.
	typedef struct packed {
		logic [2:0][COMPONENT_WIDTH-1:0] mag;
		logic [2:0]                      neg;
		logic [2:0][SUM_WIDTH-1:0]       sq;
		logic [SUM_WIDTH-1:0]            sum;
		logic                            deg;
		logic [REM_WIDTH-1:0]            rem;
		logic [ROOT_WIDTH-1:0]           root;
		logic [2:0][DIVR_WIDTH-1:0]      r;
		logic [2:0][QUOT_WIDTH-1:0]      q;
		vec_out_t                        res;
	} pipe_t;

endpackage

[sv/vector3_normalize_unit.sv]
// Vector normalizer top level: squares, sum, pipelined square root and
// three pipelined dividers. Depends on vnorm_pkg and the assertion macros.
//
//   channel | signals                  | transfer
//   input   | in_valid/in_ready/in_data | one vector per beat
//   output  | out_valid/out_ready/out_data | one unit vector per beat
//   config  | cfg_we/cfg_wdata          | threshold write, no wait
//
// The stages compute the squares, then the sum and threshold test, then the
// square root (one root bit per stage), the division (one quotient bit per stage
// in each lane), and last apply the sign. A new vector is taken every cycle
// unless an output stall backs up to the input. Each stage moves when
// the stage after it is free, so bubbles close up during an output stall.
// Reset empties the pipeline and sets the threshold to 1.
`include "vector3_normalize_unit_macros.svh"
module vector3_normalize_unit
	import vnorm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vec_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vec_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_WIDTH-1:0] cfg_wdata
);

	localparam int SQRT_FIRST = 2;
	localparam int DIV_FIRST  = SQRT_FIRST + ROOT_WIDTH;
	localparam int LAST       = DIV_FIRST + QUOT_WIDTH;
	localparam int NST        = LAST + 1;

	logic [CFG_WIDTH-1:0] thr_q;
	pipe_t                pipe_s [NST];
	pipe_t                nxt    [NST];
	logic [NST-1:0]       vld_s;
	logic [NST:0]         rdy;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= CFG_WIDTH'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// A stage can load when it is empty or the stage after it loads too.
	assign rdy[NST] = out_ready;
	for (genvar k = 0; k < NST; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[LAST];
	assign out_data  = pipe_s[LAST].res;

	// Stage 0: sign and magnitude of each component, and its square.
	always_comb begin
		logic [COMPONENT_WIDTH-1:0] raw [3];
		raw[0] = in_data.in_x;
		raw[1] = in_data.in_y;
		raw[2] = in_data.in_z;
		nxt[0] = '0;
		for (int l = 0; l < 3; l++) begin
			nxt[0].neg[l] = raw[l][COMPONENT_WIDTH-1];
			nxt[0].mag[l] = raw[l][COMPONENT_WIDTH-1] ? (~raw[l] + 1'b1) : raw[l];
			nxt[0].sq[l]  = SUM_WIDTH'(nxt[0].mag[l]) * SUM_WIDTH'(nxt[0].mag[l]);
		end
	end

	// Stage 1: sum of squares and the short vector test.
	always_comb begin
		nxt[1]      = pipe_s[0];
		nxt[1].sum  = pipe_s[0].sq[0] + pipe_s[0].sq[1] + pipe_s[0].sq[2];
		nxt[1].deg  = (nxt[1].sum == '0) || (nxt[1].sum < thr_q);
		nxt[1].rem  = '0;
		nxt[1].root = '0;
	end

	// Square root: one radicand digit pair and one root bit per stage.
	for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_sqrt
		localparam int K = SQRT_FIRST + j;
		always_comb begin
			logic [2*ROOT_WIDTH-1:0] rad;
			logic [REM_WIDTH-1:0]    rem_n;
			logic [REM_WIDTH-1:0]    trial;
			rad    = {pipe_s[K-1].sum, (2*FRACTION_EXTRA)'(0)};
			rem_n  = {pipe_s[K-1].rem[REM_WIDTH-3:0], rad[2*(ROOT_WIDTH-1-j) +: 2]};
			trial  = {1'b0, pipe_s[K-1].root, 2'b01};
			nxt[K] = pipe_s[K-1];
			if (rem_n >= trial) begin
				nxt[K].rem  = rem_n - trial;
				nxt[K].root = {pipe_s[K-1].root[ROOT_WIDTH-2:0], 1'b1};
			end else begin
				nxt[K].rem  = rem_n;
				nxt[K].root = {pipe_s[K-1].root[ROOT_WIDTH-2:0], 1'b0};
			end
		end
	end

	// Division: one quotient bit per stage in each of the three lanes.
	for (genvar j = 0; j < QUOT_WIDTH; j++) begin : g_div
		localparam int K = DIV_FIRST + j;
		always_comb begin
			logic [DIVR_WIDTH-1:0] r_in;
			logic [DIVR_WIDTH-1:0] rs;
			nxt[K] = pipe_s[K-1];
			for (int l = 0; l < 3; l++) begin
				if (j == 0) begin
					r_in = DIVR_WIDTH'({pipe_s[K-1].mag[l], DIV_PRESHIFT'(0)});
				end else begin
					r_in = pipe_s[K-1].r[l];
				end
				rs = {r_in[DIVR_WIDTH-2:0], 1'b0};
				if (rs >= {1'b0, pipe_s[K-1].root}) begin
					nxt[K].r[l] = rs - {1'b0, pipe_s[K-1].root};
					nxt[K].q[l] = {pipe_s[K-1].q[l][QUOT_WIDTH-2:0], 1'b1};
				end else begin
					nxt[K].r[l] = rs;
					nxt[K].q[l] = {pipe_s[K-1].q[l][QUOT_WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	// Last stage: apply signs and zero a short vector.
	always_comb begin
		logic [UNIT_WIDTH-1:0] u [3];
		nxt[LAST] = pipe_s[LAST-1];
		for (int l = 0; l < 3; l++) begin
			u[l] = UNIT_WIDTH'(pipe_s[LAST-1].q[l]);
			if (pipe_s[LAST-1].deg) begin
				u[l] = '0;
			end else if (pipe_s[LAST-1].neg[l]) begin
				u[l] = ~u[l] + 1'b1;
			end
		end
		nxt[LAST].res.unit_x     = u[0];
		nxt[LAST].res.unit_y     = u[1];
		nxt[LAST].res.unit_z     = u[2];
		nxt[LAST].res.degenerate = pipe_s[LAST-1].deg;
	end

	// Pipeline registers with valid bits.
	for (genvar k = 0; k < NST; k++) begin : g_regs
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= (k == 0) ? in_valid : vld_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	`VNU_ASSERT_SAME(a_deg_zero, out_valid && out_data.degenerate,
		(out_data.unit_x == '0) && (out_data.unit_y == '0) && (out_data.unit_z == '0),
		"Short vector gave a nonzero result.")
	`VNU_ASSERT_SAME(a_root_nonzero, vld_s[DIV_FIRST-1] && !pipe_s[DIV_FIRST-1].deg,
		pipe_s[DIV_FIRST-1].root != '0, "Zero magnitude reached the divider.")
	`VNU_ASSERT_SAME(a_quot_bound, vld_s[LAST-1] && !pipe_s[LAST-1].deg,
		(pipe_s[LAST-1].q[0] <= UNIT_ONE) && (pipe_s[LAST-1].q[1] <= UNIT_ONE)
		&& (pipe_s[LAST-1].q[2] <= UNIT_ONE), "Quotient exceeds unit magnitude.")
	`VNU_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, vld_s[0],
		"Accepted beat did not enter the pipeline.")

endmodule

[tb/vnorm_checker.sv]
// Checker for the vector normalizer: watches the input, output and threshold ports,
// predicts each unit vector and compares it field by field. Depends on vnorm_pkg.
`timescale 1ns / 1ps
module vnorm_checker
	import vnorm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  vec_in_t              in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  vec_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_WIDTH-1:0] cfg_wdata,
	output int                   fail_count,
	output int                   pending,
	output int                   results_seen,
	output int                   degenerate_seen
);

	logic [CFG_WIDTH-1:0] min_len_sq;
	vec_out_t             expected_units[$];

	// Unit vector of one input beat under the given threshold.
	function automatic vec_out_t normalize_vector(vec_in_t v, logic [CFG_WIDTH-1:0] thr);
		logic [COMPONENT_WIDTH-1:0] comp[3];
		logic [16:0]                mag[3];
		logic                       neg[3];
		logic [63:0]                sum;
		logic [63:0]                radicand;
		logic [63:0]                root;
		logic [63:0]                trial;
		logic [63:0]                q;
		logic [UNIT_WIDTH-1:0]      unit[3];
		vec_out_t                   r;
		comp[0] = v.in_x;
		comp[1] = v.in_y;
		comp[2] = v.in_z;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = comp[i][COMPONENT_WIDTH-1];
			mag[i] = neg[i] ? 17'(32'd65536 - 32'(comp[i])) : 17'(comp[i]);
			sum += 64'(mag[i]) * 64'(mag[i]);
		end
		if (sum == 0 || sum < 64'(thr)) begin
			r.unit_x = '0;
			r.unit_y = '0;
			r.unit_z = '0;
			r.degenerate = 1'b1;
			return r;
		end
		// Magnitude with eight extra fraction bits, rounded down.
		radicand = sum << 16;
		root = 0;
		for (int b = 27; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand) begin
				root = trial;
			end
		end
		for (int i = 0; i < 3; i++) begin
			q = (64'(mag[i]) << 22) / root;
			if (q > 16384) begin
				q = 16384;
			end
			unit[i] = neg[i] ? UNIT_WIDTH'(-q) : UNIT_WIDTH'(q);
		end
		r.unit_x = unit[0];
		r.unit_y = unit[1];
		r.unit_z = unit[2];
		r.degenerate = 1'b0;
		return r;
	endfunction

	// Track the threshold, queue predictions and compare result beats.
	always @(posedge clk or negedge arst_n) begin
		vec_out_t want;
		if (!arst_n) begin
			min_len_sq = 1;
			expected_units.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			degenerate_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.degenerate) begin
					degenerate_seen++;
				end
				if (expected_units.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected result beat %h", $realtime, out_data);
					end
				end else begin
					want = expected_units.pop_front();
					if (want.unit_x !== out_data.unit_x || want.unit_y !== out_data.unit_y
						|| want.unit_z !== out_data.unit_z
						|| want.degenerate !== out_data.degenerate) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch x %0d/%0d y %0d/%0d z %0d/%0d deg %b/%b",
								$realtime, want.unit_x, out_data.unit_x, want.unit_y,
								out_data.unit_y, want.unit_z, out_data.unit_z,
								want.degenerate, out_data.degenerate);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_units.push_back(normalize_vector(in_data, min_len_sq));
			end
			if (cfg_we) begin
				min_len_sq = cfg_wdata;
			end
			pending = expected_units.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the vector normalizer testbench: clock, reset, vector stimulus, output stalls
// and the verdict. Depends on vnorm_pkg, vector3_normalize_unit and vnorm_checker.
`timescale 1ns / 1ps
module testbench;
	import vnorm_pkg::*;

	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	vec_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	vec_out_t             out_data;
	logic                 cfg_we;
	logic [CFG_WIDTH-1:0] cfg_wdata;
	int                   fail_count;
	int                   pending;
	int                   results_seen;
	int                   degenerate_seen;
	int                   idle_mode;
	int                   holds_asked;
	int                   holds_done;
	int                   hold_left;
	int                   thresholds_used;

	vector3_normalize_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	vnorm_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.degenerate_seen(degenerate_seen)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random stalls by phase, plus a long hold-off when one is asked for.
	initial begin
		out_ready = 1'b0;
		holds_done = 0;
		hold_left = 0;
	end
	always @(negedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done = holds_asked;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (idle_mode == IDLE_RECEIVER) begin
			out_ready <= ($urandom_range(99) >= 55);
		end else if (idle_mode == IDLE_BOTH) begin
			out_ready <= ($urandom_range(99) >= 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one vector beat and hold it until it is taken; called just after a falling edge.
	task automatic send_vector(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 55 : (idle_mode == IDLE_BOTH) ? 11 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.in_x <= x;
		in_data.in_y <= y;
		in_data.in_z <= z;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	// Random vector: full range, short, on one axis, or a mid-sized mix.
	task automatic send_random_vector();
		logic [15:0] c[3];
		int          axis;
		case ($urandom_range(3))
			0: begin
				for (int i = 0; i < 3; i++) c[i] = 16'($urandom);
			end
			1: begin
				for (int i = 0; i < 3; i++) c[i] = 16'($urandom_range(512) - 256);
			end
			2: begin
				axis = $urandom_range(2);
				for (int i = 0; i < 3; i++) c[i] = (i == axis) ? 16'($urandom) : 16'h0;
			end
			default: begin
				for (int i = 0; i < 3; i++) c[i] = 16'($urandom) >>> $urandom_range(12);
			end
		endcase
		send_vector(c[0], c[1], c[2]);
	endtask

	// Stop offering and wait until every predicted beat has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [CFG_WIDTH-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		thresholds_used++;
	endtask

	// Stimulus.
	initial begin
		logic [CFG_WIDTH-1:0] phase_thr[8];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_mode = IDLE_NONE;
		holds_asked = 0;
		thresholds_used = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed vectors under the reset threshold.
		send_vector(16'h0000, 16'h0000, 16'h0000);
		send_vector(16'h7FFF, 16'h0000, 16'h0000);
		send_vector(16'h8000, 16'h0000, 16'h0000);
		send_vector(16'h0000, 16'h7FFF, 16'h0000);
		send_vector(16'h0000, 16'h0000, 16'h8000);
		send_vector(16'h8000, 16'h8000, 16'h8000);
		send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_vector(16'h0001, 16'h0000, 16'h0000);
		send_vector(16'hFFFF, 16'h0000, 16'h0000);
		send_vector(16'h0001, 16'h0001, 16'h0001);
		send_vector(16'hFFFF, 16'h0002, 16'hFFFD);
		send_vector(16'h3000, 16'h4000, 16'h0000);
		send_vector(16'h5555, 16'hAAAA, 16'h5555);
		send_vector(16'hAAAA, 16'h5555, 16'hAAAA);
		send_vector(16'h7FFF, 16'h8000, 16'h0001);
		send_vector(16'h1000, 16'hF000, 16'h1000);
		drain();

		// Short vectors against one unit of length squared, then zero threshold.
		write_threshold(32'h0100_0000);
		send_vector(16'h0FFF, 16'h0000, 16'h0000);
		send_vector(16'h1000, 16'h0000, 16'h0000);
		send_vector(16'h0800, 16'h0800, 16'h0800);
		drain();
		write_threshold(32'h0);
		send_vector(16'h0000, 16'h0000, 16'h0000);
		send_vector(16'h0000, 16'h0001, 16'h0000);
		drain();

		phase_thr = '{32'h0, 32'hFFFF_FFFF, 32'h0100_0000, 32'($urandom),
			32'h0000_1000, 32'h1, 32'($urandom_range(32'h0400_0000)), 32'hC000_0000};
		for (int p = 0; p < 8; p++) begin
			drain();
			write_threshold(phase_thr[p]);
			idle_mode = p % 4;
			if (p == 4) begin
				holds_asked++;
			end
			for (int n = 0; n < 85; n++) begin
				send_random_vector();
			end
		end
		drain();
		idle_mode = IDLE_NONE;
		$display("Checked %0d unit vectors (%0d degenerate) over %0d threshold settings.",
			results_seen, degenerate_seen, thresholds_used + 1);
		if (fail_count == 0) begin
			$display("vector3_normalize_unit regression: pass");
		end else begin
			$display("vector3_normalize_unit regression: fail");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(12 * 400000);
		$display("vector3_normalize_unit regression: fail");
		$finish;
	end

endmodule
